// ===== hw/rtl/b2da_pkg.sv =====
// Shared types and constants for the 128-bit binary to decimal ASCII converter.
// No dependencies; used by every module of the block.
`default_nettype none
package b2da_pkg;

    localparam int unsigned VALUE_W     = 128;
    localparam int unsigned HALF_W      = 64;
    localparam int unsigned MIN_W       = 6;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned CHAR_W      = 6;
    localparam int unsigned IN_DATA_W   = 136;
    localparam int unsigned OUT_DATA_W  = 8;
    localparam int unsigned MAX_DIGITS  = 39;
    // Value bits consumed per double dabble cycle.
    localparam int unsigned STEP_BITS   = 4;
    localparam int unsigned NUM_STEPS   = VALUE_W / STEP_BITS;
    localparam int unsigned STEP_CNT_W  = $clog2(NUM_STEPS);
    localparam int unsigned FIFO_DEPTH  = 2;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic [HALF_W-1:0] value_high;
        logic [HALF_W-1:0] value_low;
        logic [MIN_W-1:0]  min_digits;
    } t_item;

endpackage
`default_nettype wire

// ===== hw/rtl/b2da_front.sv =====
// Front end: accepts input transfers, clamps the minimum digit count and
// queues items in a two-entry FIFO. Depends on b2da_pkg.
`default_nettype none
module b2da_front #(
    parameter int unsigned MAX_DIGITS = b2da_pkg::MAX_DIGITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [b2da_pkg::HALF_W-1:0] i_value_low,
    input  wire logic [b2da_pkg::HALF_W-1:0] i_value_high,
    input  wire logic [b2da_pkg::MIN_W-1:0]  i_min_digits,
    output logic                       o_item_valid,
    input  wire logic                  i_item_take,
    output b2da_pkg::t_item            o_item
);

    localparam logic [b2da_pkg::MIN_W-1:0] MaxMin = b2da_pkg::MIN_W'(MAX_DIGITS);

    b2da_pkg::t_item r_mem [b2da_pkg::FIFO_DEPTH];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            w_push;
    logic            w_pop;
    b2da_pkg::t_item w_item;

    assign o_ready      = (r_count != 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign w_push       = i_valid && o_ready;
    assign w_pop        = o_item_valid && i_item_take;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        w_item.value_high = i_value_high;
        w_item.value_low  = i_value_low;
        if (i_min_digits == '0) begin
            w_item.min_digits = b2da_pkg::MIN_W'(1);
        end else if (i_min_digits > MaxMin) begin
            w_item.min_digits = MaxMin;
        end else begin
            w_item.min_digits = i_min_digits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/b2da_dabble.sv =====
// Double dabble converter: turns one 128-bit value into BCD digits, four value
// bits per cycle. Depends on b2da_pkg.
`default_nettype none
module b2da_dabble #(
    parameter int unsigned MAX_DIGITS = b2da_pkg::MAX_DIGITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_item_valid,
    output logic                                   o_item_take,
    input  wire b2da_pkg::t_item                   i_item,
    output logic                                   o_conv_valid,
    input  wire logic                              i_conv_take,
    output logic [b2da_pkg::DIGIT_W*MAX_DIGITS-1:0] o_digits,
    output logic [b2da_pkg::MIN_W-1:0]             o_min_digits
);

    localparam int unsigned BcdW = b2da_pkg::DIGIT_W * MAX_DIGITS;
    localparam logic [b2da_pkg::STEP_CNT_W-1:0] LastStep =
        b2da_pkg::STEP_CNT_W'(b2da_pkg::NUM_STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state                            r_state;
    logic [BcdW-1:0]                   r_bcd;
    logic [b2da_pkg::VALUE_W-1:0]      r_val;
    logic [b2da_pkg::STEP_CNT_W-1:0]   r_step;
    logic [b2da_pkg::MIN_W-1:0]        r_min;
    logic [BcdW-1:0]                   n_bcd;

    assign o_item_take  = (r_state == ST_IDLE);
    assign o_conv_valid = (r_state == ST_DONE);
    assign o_digits     = r_bcd;
    assign o_min_digits = r_min;

    // Four dependent add-3-then-shift steps; the carry out of the top digit is lost.
    always_comb begin
        n_bcd = r_bcd;
        for (int k = 0; k < b2da_pkg::STEP_BITS; k++) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                if (n_bcd[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= 4'd5) begin
                    n_bcd[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                        n_bcd[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BcdW-2:0], r_val[b2da_pkg::VALUE_W-1-k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_bcd   <= '0;
                        r_val   <= {i_item.value_high, i_item.value_low};
                        r_min   <= i_item.min_digits;
                        r_step  <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_bcd  <= n_bcd;
                    r_val  <= {r_val[b2da_pkg::VALUE_W-b2da_pkg::STEP_BITS-1:0],
                               {b2da_pkg::STEP_BITS{1'b0}}};
                    r_step <= r_step + 1'b1;
                    if (r_step == LastStep) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_conv_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/b2da_emit.sv =====
// Character emitter: walks the BCD digits from the top, drops leading zeros
// above the minimum count and drives the registered output. Depends on b2da_pkg.
`default_nettype none
module b2da_emit #(
    parameter int unsigned MAX_DIGITS = b2da_pkg::MAX_DIGITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_conv_valid,
    output logic                                    o_conv_take,
    input  wire logic [b2da_pkg::DIGIT_W*MAX_DIGITS-1:0] i_digits,
    input  wire logic [b2da_pkg::MIN_W-1:0]         i_min_digits,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [b2da_pkg::CHAR_W-1:0]             o_char,
    output logic                                    o_last
);

    localparam int unsigned BcdW = b2da_pkg::DIGIT_W * MAX_DIGITS;
    localparam logic [b2da_pkg::MIN_W-1:0] NumDigits = b2da_pkg::MIN_W'(MAX_DIGITS);
    localparam logic [b2da_pkg::MIN_W-1:0] OneLeft   = b2da_pkg::MIN_W'(1);

    logic [BcdW-1:0]                  r_digits;
    logic [b2da_pkg::MIN_W-1:0]       r_left;
    logic [b2da_pkg::MIN_W-1:0]       r_min;
    logic                             r_lead;
    logic                             r_busy;
    logic                             r_valid;
    logic [b2da_pkg::CHAR_W-1:0]      r_char;
    logic                             r_last;
    logic [b2da_pkg::DIGIT_W-1:0]     w_top;
    logic                             w_adv;
    logic                             w_emit;
    logic                             w_final;

    assign w_top       = r_digits[BcdW-1 -: b2da_pkg::DIGIT_W];
    assign w_adv       = r_busy && (!r_valid || i_ready);
    assign w_emit      = !r_lead || (w_top != '0) || (r_left <= r_min);
    assign w_final     = w_adv && (r_left == OneLeft);
    assign o_conv_take = i_conv_valid && (!r_busy || w_final);
    assign o_valid     = r_valid;
    assign o_char      = r_char;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (o_conv_take) begin
            r_digits <= i_digits;
            r_min    <= i_min_digits;
            r_left   <= NumDigits;
            r_lead   <= 1'b1;
        end else if (w_adv) begin
            r_digits <= {r_digits[BcdW-b2da_pkg::DIGIT_W-1:0], {b2da_pkg::DIGIT_W{1'b0}}};
            r_left   <= r_left - 1'b1;
            if (w_emit) begin
                r_lead <= 1'b0;
            end
        end
        if (w_adv && w_emit) begin
            r_char <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(w_top);
            r_last <= (r_left == OneLeft);
        end
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_conv_take) begin
                r_busy <= 1'b1;
            end else if (w_final) begin
                r_busy <= 1'b0;
            end
            if (w_adv && w_emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/binary_to_decimal_ascii_128_core.sv =====
// Unsigned 128-bit binary to decimal ASCII converter, top level.
// Each number passes the two-entry front FIFO, the double dabble converter (a
// load, 32 steps of four bits and a hand over) and the emitter, which skips
// leading zeros before the first character. Throughput is set by the emitter,
// which visits every digit position once; the converter can work on the next
// number while the emitter drains the last one.
// Reset is synchronous and active low; it clears control state only.
`default_nettype none
module binary_to_decimal_ascii_128_core #(
    parameter int unsigned MAX_DIGITS = b2da_pkg::MAX_DIGITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // value_low [63:0], value_high [127:64], min_digits [133:128], zero fill
    input  wire logic [b2da_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // digit_char [5:0], zero fill
    output logic [b2da_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    output logic                                      m_axis_tlast
);

    localparam int unsigned BcdW = b2da_pkg::DIGIT_W * MAX_DIGITS;

    logic                           w_item_valid;
    logic                           w_item_take;
    b2da_pkg::t_item                w_item;
    logic                           w_conv_valid;
    logic                           w_conv_take;
    logic [BcdW-1:0]                w_digits;
    logic [b2da_pkg::MIN_W-1:0]     w_min;
    logic [b2da_pkg::CHAR_W-1:0]    w_char;

    b2da_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_value_low  (s_axis_tdata[63:0]),
        .i_value_high (s_axis_tdata[127:64]),
        .i_min_digits (s_axis_tdata[133:128]),
        .o_item_valid (w_item_valid),
        .i_item_take  (w_item_take),
        .o_item       (w_item)
    );

    b2da_dabble #(.MAX_DIGITS(MAX_DIGITS)) u_dabble (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .o_item_take  (w_item_take),
        .i_item       (w_item),
        .o_conv_valid (w_conv_valid),
        .i_conv_take  (w_conv_take),
        .o_digits     (w_digits),
        .o_min_digits (w_min)
    );

    b2da_emit #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_conv_valid (w_conv_valid),
        .o_conv_take  (w_conv_take),
        .i_digits     (w_digits),
        .i_min_digits (w_min),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_char       (w_char),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {{(b2da_pkg::OUT_DATA_W - b2da_pkg::CHAR_W){1'b0}}, w_char};

    // Every character on the output is an ASCII decimal digit.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_char >= 6'd48) && (w_char <= 6'd57))
        else $error("output character is not a decimal digit");

    // The output register is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A converted result is handed to the emitter only once.
    a_single_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_conv_valid && w_conv_take) |=> !w_conv_valid)
        else $error("converted result handed over twice");

endmodule
`default_nettype wire
